// ===== rtl/cpw_pkg.sv =====
package cpw_pkg;

  typedef logic [2:0] degree_t;
  typedef logic [6:0] note_t;
  typedef logic [3:0] weight_t;

  localparam int unsigned NUM_DEGREES = 7;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 49;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHRASE_LENGTH    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WANDER_THRESHOLD = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_NOTES      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SIZE       = 8'd3;

  // register reset values
  localparam logic [5:0]  RST_PHRASE_LENGTH    = 6'd4;
  localparam logic [16:0] RST_WANDER_THRESHOLD = 17'd6554;
  localparam logic [48:0] RST_SCALE_NOTES      = 49'd261458125199664;
  localparam logic [2:0]  RST_SCALE_SIZE       = 3'd7;

  localparam degree_t DEG_TONIC    = 3'd0;
  localparam degree_t DEG_DOMINANT = 3'd4;

  typedef weight_t trans_row_t [NUM_DEGREES];

  // transition weights, row is the previous degree
  localparam trans_row_t TRANS [NUM_DEGREES] = '{
    '{4'd0, 4'd2, 4'd1, 4'd3, 4'd3, 4'd3, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd1, 4'd4, 4'd0, 4'd1},
    '{4'd0, 4'd0, 4'd0, 4'd2, 4'd0, 4'd3, 4'd0},
    '{4'd2, 4'd2, 4'd0, 4'd0, 4'd3, 4'd1, 4'd0},
    '{4'd4, 4'd0, 4'd0, 4'd1, 4'd0, 4'd2, 4'd0},
    '{4'd0, 4'd2, 4'd1, 4'd3, 4'd2, 4'd0, 4'd0},
    '{4'd3, 4'd0, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0}
  };

  // sum of each row, all rows stay below 16
  localparam weight_t ROW_SUM [NUM_DEGREES] = '{
    4'd12, 4'd6, 4'd5, 4'd8, 4'd7, 4'd8, 4'd4
  };

  // first degree whose running weight sum exceeds r
  function automatic degree_t table_pick(input degree_t row, input weight_t r);
    weight_t acc;
    logic    found;
    degree_t res;
    acc   = '0;
    found = 1'b0;
    res   = DEG_TONIC;
    for (int i = 0; i < NUM_DEGREES; i++) begin
      acc = acc + TRANS[row][i];
      if (!found && (r < acc)) begin
        res   = degree_t'(i);
        found = 1'b1;
      end
    end
    return res;
  endfunction

  // degree modulo scale size, degree below 7 and size at least 1
  function automatic degree_t degree_mod(input degree_t deg, input logic [2:0] size);
    degree_t s;
    s = deg;
    for (int i = 0; i < NUM_DEGREES - 1; i++) begin
      if (s >= size) begin
        s = s - size;
      end
    end
    return s;
  endfunction

endpackage

// ===== rtl/chord_progression_walker.sv =====
// path: a taken word waits in the input register, then its chord loads the result register
// throughput: one word per cycle while in_stall is low; ticks with no chord make no result
// the input register and the result register are decoupled, so a waiting result does not
// block the next word unless that word also makes a chord
// reset (rst, synchronous, active high) clears both stages, phrase position and previous
// degree, and loads the register defaults; config writes are always ready
module chord_progression_walker import cpw_pkg::*; #(
  parameter int unsigned PHRASE_MAX = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // config write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // tick input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  running,
  input  logic [15:0]           chance,
  input  logic [15:0]           pick,
  // chord output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output note_t                 note,
  output degree_t               degree
);

  // position counter width and the width used for phrase compares
  localparam int unsigned POS_W  = (PHRASE_MAX > 1) ? $clog2(PHRASE_MAX) : 1;
  localparam int unsigned LEN_W  = $clog2(PHRASE_MAX + 1);
  localparam int unsigned CMP_W  = (LEN_W > 6) ? LEN_W : 6;

  // configuration registers
  logic [5:0]  phrase_length;
  logic [16:0] wander_threshold;
  logic [48:0] scale_notes;
  logic [2:0]  scale_size;

  // walker state
  logic [POS_W-1:0] phrase_position;
  degree_t          prev_degree;

  // input register
  logic        s1_valid;
  logic        s1_running;
  logic [15:0] s1_chance;
  logic [15:0] s1_pick;

  logic in_accept;
  logic cfg_write;
  logic fire;
  logic out_free;
  logic s1_move;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // a result slot is free when empty or being drained this cycle
  assign out_free  = !out_valid || !out_stall;
  // a word that makes no chord never waits for the result slot
  assign fire      = s1_valid && s1_running && (scale_size != 3'd0);
  assign s1_move   = !fire || out_free;
  assign in_stall  = s1_valid && !s1_move;
  assign in_accept = in_valid && !in_stall;

  // effective phrase length, saturated to 1..PHRASE_MAX
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] phrase;
  logic [CMP_W-1:0] k_cur;
  logic [CMP_W-1:0] k_inc;
  logic [CMP_W-1:0] k_next;

  always_comb begin
    len_ext = CMP_W'(phrase_length);
    if (len_ext == '0) begin
      phrase = CMP_W'(1);
    end else if (len_ext > CMP_W'(PHRASE_MAX)) begin
      phrase = CMP_W'(PHRASE_MAX);
    end else begin
      phrase = len_ext;
    end
    // a stale position past the phrase end restarts the phrase
    k_cur  = (CMP_W'(phrase_position) >= phrase) ? '0 : CMP_W'(phrase_position);
    k_inc  = k_cur + CMP_W'(1);
    k_next = (k_inc >= phrase) ? '0 : k_inc;
  end

  // degree draw
  degree_t     from_row;
  logic        wander;
  logic [18:0] uni_prod;
  logic [19:0] tbl_prod;
  degree_t     drawn;
  degree_t     deg_sel;
  degree_t     slot;
  note_t       scale_tab [NUM_DEGREES];

  always_comb begin
    from_row = (prev_degree > 3'd6) ? DEG_TONIC : prev_degree;
    wander   = {1'b0, s1_chance} < wander_threshold;
    // pick * 7 as shift and subtract
    uni_prod = {s1_pick, 3'b000} - {3'b000, s1_pick};
    tbl_prod = {4'b0000, s1_pick} * {16'h0000, ROW_SUM[from_row]};
    if (wander) begin
      drawn = uni_prod[18:16];
    end else begin
      drawn = table_pick(from_row, tbl_prod[19:16]);
    end

    // tonic opens the phrase, dominant closes it
    if (k_cur == '0) begin
      deg_sel = DEG_TONIC;
    end else if (k_cur == phrase - CMP_W'(1)) begin
      deg_sel = DEG_DOMINANT;
    end else begin
      deg_sel = drawn;
    end

    slot = degree_mod(deg_sel, scale_size);
    for (int i = 0; i < NUM_DEGREES; i++) begin
      scale_tab[i] = scale_notes[7*i +: 7];
    end
  end

  // config registers and walker state
  always_ff @(posedge clk) begin
    if (rst) begin
      phrase_length    <= RST_PHRASE_LENGTH;
      wander_threshold <= RST_WANDER_THRESHOLD;
      scale_notes      <= RST_SCALE_NOTES;
      scale_size       <= RST_SCALE_SIZE;
      phrase_position  <= '0;
      prev_degree      <= DEG_TONIC;
    end else begin
      // chord emitted: advance the walk
      if (fire && out_free) begin
        prev_degree     <= deg_sel;
        phrase_position <= k_next[POS_W-1:0];
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_PHRASE_LENGTH: begin
            phrase_length   <= cfg_data[5:0];
            phrase_position <= '0;
          end
          REG_WANDER_THRESHOLD: wander_threshold <= cfg_data[16:0];
          REG_SCALE_NOTES:      scale_notes      <= cfg_data[48:0];
          REG_SCALE_SIZE:       scale_size       <= cfg_data[2:0];
          default: begin
          end
        endcase
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_running <= running;
      s1_chance  <= chance;
      s1_pick    <= pick;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && out_free) begin
      note   <= scale_tab[slot];
      degree <= deg_sel;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

// expected chord store with its own copy of the walker state
class chord_scoreboard;

  typedef struct {
    cpw_pkg::note_t   note;
    cpw_pkg::degree_t degree;
  } chord_t;

  // register shadows
  logic [5:0]       phrase_len;
  logic [16:0]      wander;
  logic [48:0]      scale;
  logic [2:0]       size;
  // walker state
  logic [4:0]       position;
  cpw_pkg::degree_t last_degree;

  int unsigned      phrase_cap;
  int unsigned      weights [7][7];
  chord_t           expected_chords [$];
  int unsigned      ticks_noted;
  int unsigned      mismatches;

  function new(input int unsigned cap);
    phrase_cap  = cap;
    weights     = '{'{0, 2, 1, 3, 3, 3, 0},
                    '{0, 0, 0, 1, 4, 0, 1},
                    '{0, 0, 0, 2, 0, 3, 0},
                    '{2, 2, 0, 0, 3, 1, 0},
                    '{4, 0, 0, 1, 0, 2, 0},
                    '{0, 2, 1, 3, 2, 0, 0},
                    '{3, 0, 1, 0, 0, 0, 0}};
    phrase_len  = cpw_pkg::RST_PHRASE_LENGTH;
    wander      = cpw_pkg::RST_WANDER_THRESHOLD;
    scale       = cpw_pkg::RST_SCALE_NOTES;
    size        = cpw_pkg::RST_SCALE_SIZE;
    position    = '0;
    last_degree = cpw_pkg::DEG_TONIC;
    ticks_noted = 0;
    mismatches  = 0;
  endfunction

  function int unsigned pending();
    return expected_chords.size();
  endfunction

  function void write_reg(input logic [cpw_pkg::CFG_IDX_W-1:0] idx,
                          input logic [cpw_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      cpw_pkg::REG_PHRASE_LENGTH: begin
        phrase_len = data[5:0];
        position   = '0;
      end
      cpw_pkg::REG_WANDER_THRESHOLD: wander = data[16:0];
      cpw_pkg::REG_SCALE_NOTES:      scale  = data[48:0];
      cpw_pkg::REG_SCALE_SIZE:       size   = data[2:0];
      default: ;
    endcase
  endfunction

  // next degree away from the phrase ends
  function cpw_pkg::degree_t choose_degree(input logic [15:0] ch, input logic [15:0] pk);
    int unsigned from;
    int unsigned total;
    int unsigned r;
    from = last_degree;
    if (from > 6) from = 0;
    if ({1'b0, ch} < wander) return cpw_pkg::degree_t'((32'(pk) * 7) >> 16);
    total = 0;
    for (int i = 0; i < 7; i++) total += weights[from][i];
    if (total == 0) return cpw_pkg::DEG_TONIC;
    r = (32'(pk) * total) >> 16;
    for (int i = 0; i < 7; i++) begin
      if (r < weights[from][i]) return cpw_pkg::degree_t'(i);
      r -= weights[from][i];
    end
    return cpw_pkg::DEG_TONIC;
  endfunction

  // accepted tick word: works out the chord it makes, if any
  function void note_tick(input logic run, input logic [15:0] ch, input logic [15:0] pk);
    int unsigned      len;
    int unsigned      k;
    int unsigned      slot;
    cpw_pkg::degree_t dg;
    chord_t           c;
    ticks_noted++;
    if (!run || size == 0) return;
    if (phrase_len == 0) len = 1;
    else if (phrase_len > phrase_cap) len = phrase_cap;
    else len = phrase_len;
    k = position;
    if (k >= len) k = 0;
    if (k == 0) dg = cpw_pkg::DEG_TONIC;
    else if (k == len - 1) dg = cpw_pkg::DEG_DOMINANT;
    else dg = choose_degree(ch, pk);
    slot     = dg % size;
    c.note   = cpw_pkg::note_t'(scale >> (7 * slot));
    c.degree = dg;
    expected_chords.push_back(c);
    last_degree = dg;
    k++;
    if (k >= len) k = 0;
    position = 5'(k);
  endfunction

  task report_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  task check_chord(input cpw_pkg::note_t nt, input cpw_pkg::degree_t dg);
    chord_t want;
    if (expected_chords.size() == 0) begin
      report_mismatch($sformatf("chord note %0d degree %0d with none expected", nt, dg));
      return;
    end
    want = expected_chords.pop_front();
    if (dg !== want.degree)
      report_mismatch($sformatf("degree %0d, expected %0d", dg, want.degree));
    if (nt !== want.note)
      report_mismatch($sformatf("note %0d, expected %0d", nt, want.note));
  endtask

endclass

module tb_top;
  import cpw_pkg::*;

  localparam int unsigned PHRASE_CAP     = 32;
  localparam int unsigned DRAIN_CYCLES   = 4;     // pipeline is two stages deep
  localparam int unsigned HOLD_CYCLES    = 64;    // long receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no word moving
  localparam int unsigned PHASE_TICKS    = 122;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned REG_COUNT      = 4;     // first index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(200);

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  running   = 1'b0;
  logic [15:0]           chance    = '0;
  logic [15:0]           pick      = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  note_t                 note;
  degree_t               degree;

  chord_scoreboard sb = new(PHRASE_CAP);

  // sender bookkeeping
  int unsigned burst_left = 1;
  int unsigned sent_ticks = 0;
  bit          valid_up   = 1'b0;

  // receiver pattern and the one long hold-off
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;
  logic        hold_req   = 1'b0;
  logic        hold_done  = 1'b0;

  int unsigned quiet = 0;

  chord_progression_walker #(.PHRASE_MAX(PHRASE_CAP)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .running   (running),
    .chance    (chance),
    .pick      (pick),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .note      (note),
    .degree    (degree)
  );

  always #10 clk = ~clk;

  // monitor: all three channels sampled at the edge where a word moves
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_chord(note, degree);
      if (in_valid && !in_stall) sb.note_tick(running, chance, pick);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // receiver: random stall modes of random length, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(20, 200);
      out_stall  <= 1'b0;
    end else begin
      mode_left <= mode_left - 1;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  // watchdog: any cycle with no word moving on any channel counts toward the limit
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("chord_progression_walker regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // offer one tick word and hold it until taken; bursts end in a random gap
  task automatic send_tick(input logic r, input logic [15:0] c, input logic [15:0] p);
    in_valid <= 1'b1;
    running  <= r;
    chance   <= c;
    pick     <= p;
    valid_up = 1'b1;
    do @(posedge clk); while (in_stall);
    sent_ticks++;
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // mostly short bursts, now and then a long run with no gap
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(40, 80);
      else burst_left = $urandom_range(1, 16);
    end
  endtask

  // config writes go back to back; cfg_valid stays up until cfg_idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic cfg_idle();
    cfg_valid <= 1'b0;
  endtask

  // stop offering, wait for every chord to come out, then let the pipe empty
  task automatic settle();
    if (valid_up) in_valid <= 1'b0;
    valid_up = 1'b0;
    while (sb.ticks_noted != sent_ticks || sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sometimes sets bits above the field, which the register must drop
  function automatic logic [CFG_DATA_W-1:0] stray_bits(input logic [CFG_DATA_W-1:0] v,
                                                       input int unsigned w);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'({$urandom, $urandom});
    if ($urandom_range(0, 3) == 0) return v | (junk << w);
    return v;
  endfunction

  task automatic run_random_phase(input int unsigned ticks, input bit with_hold);
    logic [CFG_DATA_W-1:0] len_w;
    logic [CFG_DATA_W-1:0] thr_w;
    logic [CFG_DATA_W-1:0] size_w;
    logic                  r;
    logic [15:0]           c;
    logic [15:0]           p;
    settle();
    // phrase length: extremes, short phrases, out of range
    case ($urandom_range(0, 9))
      0:       len_w = 0;
      1:       len_w = 1;
      2:       len_w = 2;
      3:       len_w = PHRASE_CAP;
      4:       len_w = CFG_DATA_W'($urandom_range(PHRASE_CAP + 1, 63));
      default: len_w = CFG_DATA_W'($urandom_range(3, 12));
    endcase
    // wander threshold: never, always, above always, edges
    case ($urandom_range(0, 7))
      0:       thr_w = 0;
      1:       thr_w = 65536;
      2:       thr_w = CFG_DATA_W'($urandom_range(65537, 131071));
      3:       thr_w = 65535;
      default: thr_w = CFG_DATA_W'($urandom_range(0, 65535));
    endcase
    size_w = CFG_DATA_W'($urandom_range(1, 7));
    if (with_hold) begin
      len_w  = 8;
      size_w = 7;
    end
    cfg_write(REG_PHRASE_LENGTH, stray_bits(len_w, 6));
    cfg_write(REG_WANDER_THRESHOLD, stray_bits(thr_w, 17));
    cfg_write(REG_SCALE_NOTES, CFG_DATA_W'({$urandom, $urandom}));
    cfg_write(REG_SCALE_SIZE, stray_bits(size_w, 3));
    if ($urandom_range(0, 1) == 0)
      cfg_write(CFG_IDX_W'($urandom_range(REG_COUNT, 255)), CFG_DATA_W'({$urandom, $urandom}));
    cfg_idle();
    // hold-off while the sender keeps offering fills the block
    if (with_hold) hold_req <= 1'b1;
    for (int i = 0; i < ticks; i++) begin
      r = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 9))
        0:       c = 16'h0000;
        1:       c = 16'hFFFF;
        2:       c = sb.wander[15:0];
        3:       c = sb.wander[15:0] - 16'd1;
        default: c = 16'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0:       p = 16'h0000;
        1:       p = 16'hFFFF;
        default: p = 16'($urandom);
      endcase
      send_tick(r, c, p);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 16);

    // reset settings: idle word, then a full four chord phrase and more
    send_tick(1'b0, 16'h0000, 16'h0000);
    send_tick(1'b1, 16'h0000, 16'h0000);  // tonic
    send_tick(1'b1, 16'h0000, 16'h0000);  // wander, lowest pick
    send_tick(1'b1, 16'hFFFF, 16'hFFFF);  // table, top of row
    send_tick(1'b1, 16'h0000, 16'h0000);  // dominant
    send_tick(1'b1, 16'h0000, 16'hFFFF);
    send_tick(1'b1, 16'h0000, 16'hFFFF);  // wander, highest pick
    send_tick(1'b1, 16'hFFFF, 16'h0000);  // table, bottom of row
    settle();

    // two chord phrase, empty scale, unmapped index ignored
    cfg_write(REG_PHRASE_LENGTH, 2);
    cfg_write(REG_WANDER_THRESHOLD, 131071);
    cfg_write(REG_SCALE_NOTES, '1);
    cfg_write(REG_SCALE_SIZE, 0);
    cfg_write(REG_UNMAPPED, '1);
    cfg_idle();
    send_tick(1'b1, 16'h1234, 16'h4321);  // empty scale: no chord, no state change
    settle();
    cfg_write(REG_SCALE_SIZE, 3);
    cfg_idle();
    repeat (4) send_tick(1'b1, 16'hFFFF, 16'hFFFF);
    settle();

    // zero length acts as one: tonic only; never wander
    cfg_write(REG_PHRASE_LENGTH, 0);
    cfg_write(REG_WANDER_THRESHOLD, 0);
    cfg_write(REG_SCALE_NOTES, 49'h0_1234_5678_9ABC);
    cfg_write(REG_SCALE_SIZE, 7);
    cfg_idle();
    send_tick(1'b1, 16'h0000, 16'hFFFF);
    send_tick(1'b1, 16'hFFFF, 16'h8000);
    settle();

    // length above the cap saturates; threshold at exactly always
    cfg_write(REG_PHRASE_LENGTH, 63);
    cfg_write(REG_WANDER_THRESHOLD, 65536);
    cfg_idle();
    send_tick(1'b1, 16'hFFFF, 16'hFFFF);
    send_tick(1'b1, 16'hFFFF, 16'h0000);
    send_tick(1'b1, 16'hFFFF, 16'h8000);
    settle();

    // length write mid phrase restarts at the tonic
    cfg_write(REG_PHRASE_LENGTH, 5);
    cfg_idle();
    send_tick(1'b1, 16'h0000, 16'h9000);
    send_tick(1'b1, 16'h0000, 16'h9000);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) run_random_phase(PHASE_TICKS, ph == 1);
    settle();

    if (sb.mismatches == 0) begin
      $display("chord_progression_walker regression: pass");
    end else begin
      $display("chord_progression_walker regression: fail");
    end
    $finish;
  end

endmodule
